[src/tkcd_pkg.sv]
`timescale 1ns / 1ps

package tkcd_pkg;

   localparam int OID_W  = 32;
   localparam int VLIM_W = 10;
   localparam int LIFE_W = 16;
   localparam int SLOT_W = 5;
   localparam int LIVE_W = 6;

   localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd180;
   localparam logic [LIVE_W-1:0] LIVE_MAX       = 6'd63;

   localparam logic ACT_LOOKUP    = 1'b0;
   localparam logic ACT_FRAME_END = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [LIFE_W-1:0] lifetime;
      logic [VLIM_W-1:0] vlim;
      logic [OID_W-1:0]  oid;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic scan_rd;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
   } sts_type;

endpackage

[src/tkcd_req_if.sv]
`timescale 1ns / 1ps

interface tkcd_req_if import tkcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [OID_W-1:0]  object_id;
   logic [VLIM_W-1:0] batch_vertex_limit;

   modport source (output valid, action, object_id, batch_vertex_limit, input ready);
   modport sink   (input valid, action, object_id, batch_vertex_limit, output ready);
endinterface

[src/tkcd_rsp_if.sv]
`timescale 1ns / 1ps

interface tkcd_rsp_if import tkcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic [SLOT_W-1:0] slot;
   logic              table_full;
   logic [LIVE_W-1:0] live_entries;

   modport source (output valid, hit, slot, table_full, live_entries, input ready);
   modport sink   (input valid, hit, slot, table_full, live_entries, output ready);
endinterface

[src/ttl_keyed_cache_directory.sv]
`timescale 1ns / 1ps

// Fully associative directory of ENTRIES slots keyed by {object_id, batch_vertex_limit},
// each with a frame-count lifetime. A lookup beat refreshes a matching slot, else inserts
// into the lowest free slot or, with none free, flags the table full; a frame-end beat
// ages every slot and drops expired ones. Every beat returns one response beat. The
// slot memory has one read port and is walked one slot per cycle: a beat is taken, then
// each slot is read (registered) and compared, then the response is finished once the
// output register is free or being read. After reset the memory is cleared one slot per
// cycle with req_if.ready low; csr writes are taken at any time. A finished response
// waits in an output register, so the next request beat is taken while it is pending.
module ttl_keyed_cache_directory import tkcd_pkg::*; #(
   parameter int ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   tkcd_req_if.sink          req_if,
   tkcd_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic [LIFE_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   tkcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tkcd_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_action             (req_if.action),
      .req_object_id          (req_if.object_id),
      .req_batch_vertex_limit (req_if.batch_vertex_limit),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .rsp_hit                (rsp_if.hit),
      .rsp_slot               (rsp_if.slot),
      .rsp_table_full         (rsp_if.table_full),
      .rsp_live_entries       (rsp_if.live_entries)
   );

endmodule

[src/tkcd_ctrl.sv]
`timescale 1ns / 1ps

module tkcd_ctrl import tkcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/tkcd_dpath.sv]
`timescale 1ns / 1ps

module tkcd_dpath import tkcd_pkg::*; #(
   parameter int ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_action,
   input  logic [OID_W-1:0]  req_object_id,
   input  logic [VLIM_W-1:0] req_batch_vertex_limit,
   input  logic              csr_we,
   input  logic [LIFE_W-1:0] csr_wdata,
   output logic              rsp_hit,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_table_full,
   output logic [LIVE_W-1:0] rsp_live_entries
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   logic [LIFE_W-1:0] lifetime_ff;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              cmp_valid_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              action_ff;
   logic [OID_W-1:0]  oid_ff;
   logic [VLIM_W-1:0] vlim_ff;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]  live_ff, live_in;

   logic              key_eq;
   logic [LIFE_W-1:0] aged_life;
   logic              aged_valid;
   logic              insert;
   logic              hit_in;
   logic [SLOT_W-1:0] slot_in;
   logic              full_in;
   logic [LIVE_W-1:0] live_out_in;

   assign sts.idx_last = (rd_idx_ff == IDX_LAST);

   always_comb begin
      if (cmd.clear_wr || cmd.scan_rd) begin
         rd_idx_in = sts.idx_last ? '0 : rd_idx_ff + 1'b1;
      end else if (cmd.accept) begin
         rd_idx_in = '0;
      end else begin
         rd_idx_in = rd_idx_ff;
      end
   end

   assign key_eq     = (rd_data_ff.oid == oid_ff) && (rd_data_ff.vlim == vlim_ff);
   assign aged_life  = (rd_data_ff.lifetime != '0) ? rd_data_ff.lifetime - 1'b1 : '0;
   assign aged_valid = rd_data_ff.valid && (aged_life != '0);
   assign insert     = (action_ff == ACT_LOOKUP) && !found_ff && free_ff;

   always_comb begin
      found_in     = found_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      live_in      = live_ff;
      if (cmd.accept) begin
         found_in = 1'b0;
         free_in  = 1'b0;
      end else if (cmp_valid_ff) begin
         if (action_ff == ACT_FRAME_END) begin
            if (rd_data_ff.valid && !aged_valid) begin
               live_in = live_ff - 1'b1;
            end
         end else if (rd_data_ff.valid) begin
            if (!found_ff && key_eq) begin
               found_in     = 1'b1;
               match_idx_in = cmp_idx_ff;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end else if (cmd.finish && insert) begin
         live_in = live_ff + 1'b1;
      end
   end

   // one write port: clearing pass, aging write-back, or final hit/insert update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmp_valid_ff && action_ff == ACT_FRAME_END) begin
         wr_en            = 1'b1;
         wr_addr          = cmp_idx_ff;
         wr_data          = rd_data_ff;
         wr_data.lifetime = aged_life;
         wr_data.valid    = aged_valid;
      end else if (cmd.finish && action_ff == ACT_LOOKUP && (found_ff || free_ff)) begin
         wr_en            = 1'b1;
         wr_addr          = found_ff ? match_idx_ff : free_idx_ff;
         wr_data.valid    = 1'b1;
         wr_data.lifetime = lifetime_ff;
         wr_data.vlim     = vlim_ff;
         wr_data.oid      = oid_ff;
      end
   end

   always_comb begin
      hit_in  = 1'b0;
      slot_in = '0;
      full_in = 1'b0;
      if (action_ff == ACT_LOOKUP) begin
         if (found_ff) begin
            hit_in  = 1'b1;
            slot_in = SLOT_W'(match_idx_ff);
         end else if (free_ff) begin
            slot_in = SLOT_W'(free_idx_ff);
         end else begin
            full_in = 1'b1;
         end
      end
      if (32'(live_in) > 32'(LIVE_MAX)) begin
         live_out_in = LIVE_MAX;
      end else begin
         live_out_in = LIVE_W'(live_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff  <= LIFETIME_RESET;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         live_ff      <= '0;
      end else begin
         if (csr_we) begin
            lifetime_ff <= csr_wdata;
         end
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmd.scan_rd;
         live_ff      <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= rd_idx_ff;
      found_ff     <= found_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      if (cmd.accept) begin
         action_ff <= req_action;
         oid_ff    <= req_object_id;
         vlim_ff   <= req_batch_vertex_limit;
      end
      if (cmd.finish) begin
         rsp_hit          <= hit_in;
         rsp_slot         <= slot_in;
         rsp_table_full   <= full_in;
         rsp_live_entries <= live_out_in;
      end
   end

endmodule

[sim/ttl_keyed_cache_directory_tb.sv]
`timescale 1ns / 1ps

package tkcd_tb_pkg;
   import tkcd_pkg::*;

   localparam int DIR_SLOTS = 32;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              table_full;
      logic [LIVE_W-1:0] live_entries;
   } reply_type;

   // shadow copy of the directory plus the replies it owes
   class directory_shadow;
      bit              slot_live [DIR_SLOTS];
      bit [OID_W-1:0]  slot_oid  [DIR_SLOTS];
      bit [VLIM_W-1:0] slot_vlim [DIR_SLOTS];
      bit [LIFE_W-1:0] slot_ttl  [DIR_SLOTS];
      bit [LIFE_W-1:0] lifetime_frames;
      reply_type       replies_due [$];
      int unsigned     mismatches;

      function new();
         lifetime_frames = LIFETIME_RESET;
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         mismatches = 0;
      endfunction

      function void set_lifetime(bit [LIFE_W-1:0] value);
         lifetime_frames = value;
      endfunction

      function int unsigned waiting();
         return replies_due.size();
      endfunction

      function void accept_request(logic act, logic [OID_W-1:0] oid, logic [VLIM_W-1:0] vlim);
         reply_type   reply;
         bit          found;
         bit          have_free;
         int unsigned free_slot;
         int unsigned live;
         reply     = '0;
         found     = 1'b0;
         have_free = 1'b0;
         free_slot = 0;
         live      = 0;
         if (act == ACT_FRAME_END) begin
            for (int i = 0; i < DIR_SLOTS; i++) begin
               if (slot_live[i]) begin
                  if (slot_ttl[i] != 0) slot_ttl[i]--;
                  if (slot_ttl[i] == 0) slot_live[i] = 1'b0;
               end
            end
         end else begin
            for (int i = 0; i < DIR_SLOTS; i++) begin
               if (slot_live[i]) begin
                  if (!found && slot_oid[i] == oid && slot_vlim[i] == vlim) begin
                     found       = 1'b1;
                     slot_ttl[i] = lifetime_frames;
                     reply.slot  = SLOT_W'(i);
                  end
               end else if (!have_free) begin
                  have_free = 1'b1;
                  free_slot = i;
               end
            end
            if (found) begin
               reply.hit = 1'b1;
            end else if (have_free) begin
               slot_live[free_slot] = 1'b1;
               slot_oid[free_slot]  = oid;
               slot_vlim[free_slot] = vlim;
               slot_ttl[free_slot]  = lifetime_frames;
               reply.slot           = SLOT_W'(free_slot);
            end else begin
               reply.table_full = 1'b1;
            end
         end
         foreach (slot_live[i]) if (slot_live[i]) live++;
         reply.live_entries = (live > LIVE_MAX) ? LIVE_MAX : LIVE_W'(live);
         replies_due = {replies_due, reply};
      endfunction

      task report_mismatch(string what);
         if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, what);
         mismatches++;
      endtask

      task check_reply(reply_type got);
         reply_type want;
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("reply beat %h with nothing outstanding", got));
            return;
         end
         want = replies_due.pop_front();
         if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
         if (got.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
         if (got.table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, expected %b",
                                      got.table_full, want.table_full));
         if (got.live_entries !== want.live_entries)
            report_mismatch($sformatf("live_entries %0d, expected %0d",
                                      got.live_entries, want.live_entries));
      endtask
   endclass

endpackage

module ttl_keyed_cache_directory_tb;
   import tkcd_pkg::*;
   import tkcd_tb_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int KEY_POOL    = 48;
   localparam int SETTLE      = DIR_SLOTS + 8;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 183;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [LIFE_W-1:0] csr_wdata;

   tkcd_req_if req_if ();
   tkcd_rsp_if rsp_if ();

   directory_shadow   book = new();
   int unsigned       cycles = 0;
   int unsigned       burst_left = 0;
   logic [OID_W-1:0]  pool_oid  [KEY_POOL];
   logic [VLIM_W-1:0] pool_vlim [KEY_POOL];

   ttl_keyed_cache_directory dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            book.check_reply(reply_type'{hit: rsp_if.hit, slot: rsp_if.slot,
                                         table_full: rsp_if.table_full,
                                         live_entries: rsp_if.live_entries});
         if (req_if.valid && req_if.ready)
            book.accept_request(req_if.action, req_if.object_id, req_if.batch_vertex_limit);
      end
   end

   // response backpressure: free-running, short jitter, or long stalls
   initial begin
      int unsigned stall_run;
      int unsigned stall_mode;
      rsp_if.ready <= 1'b0;
      stall_run  = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
         if (stall_run != 0) begin
            rsp_if.ready <= 1'b0;
            stall_run--;
         end else begin
            rsp_if.ready <= 1'b1;
            case (stall_mode)
               1: if ($urandom_range(0, 1) == 1) stall_run = $urandom_range(1, 3);
               2: if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(10, 60);
               default: ;
            endcase
         end
      end
   end

   task automatic issue_request(input logic act, input logic [OID_W-1:0] oid,
                                input logic [VLIM_W-1:0] vlim);
      req_if.valid              <= 1'b1;
      req_if.action             <= act;
      req_if.object_id          <= oid;
      req_if.batch_vertex_limit <= vlim;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 50)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic drain_replies();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (book.waiting() != 0);
      repeat (SETTLE) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_lifetime(input logic [LIFE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      book.set_lifetime(value);
   endtask

   task automatic random_phase(input logic [LIFE_W-1:0] life, input int unsigned items);
      int unsigned       span;
      int unsigned       frame_pct;
      int unsigned       pick;
      int unsigned       k;
      logic [OID_W-1:0]  oid;
      logic [VLIM_W-1:0] vlim;
      drain_replies();
      write_lifetime(life);
      span      = (life > 100) ? KEY_POOL : $urandom_range(6, KEY_POOL);
      frame_pct = $urandom_range(8, 30);
      repeat (items) begin
         if ($urandom_range(0, 249) == 0) drain_replies();
         pace_sender();
         pick = $urandom_range(0, 99);
         k    = $urandom_range(0, span - 1);
         oid  = pool_oid[k];
         vlim = pool_vlim[k];
         if (pick < frame_pct)
            issue_request(ACT_FRAME_END, $urandom, VLIM_W'($urandom));
         else if (pick < 92)
            issue_request(ACT_LOOKUP, oid, vlim);
         else if (pick < 96)
            issue_request(ACT_LOOKUP, oid ^ (32'h1 << $urandom_range(0, 31)), vlim);
         else
            issue_request(ACT_LOOKUP, $urandom, VLIM_W'($urandom));
      end
   endtask

   initial begin
      logic [LIFE_W-1:0] phase_life [PHASES];
      req_if.valid              <= 1'b0;
      req_if.action             <= ACT_LOOKUP;
      req_if.object_id          <= '0;
      req_if.batch_vertex_limit <= '0;
      csr_we                    <= 1'b0;
      csr_wdata                 <= '0;
      reset                     <= 1'b1;

      // key pool with keys that share one half of another key
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_oid[i]  = $urandom;
         pool_vlim[i] = VLIM_W'($urandom_range(0, 1023));
         case (i % 4)
            1: pool_oid[i]  = pool_oid[i-1];
            2: pool_vlim[i] = pool_vlim[i-1];
            3: pool_oid[i]  = pool_oid[i-1] ^ (32'h1 << $urandom_range(0, 31));
            default: ;
         endcase
      end
      phase_life = '{16'd3, 16'd1, 16'd0, 16'hFFFF, LIFETIME_RESET,
                     LIFE_W'($urandom_range(2, 12)), LIFE_W'($urandom_range(0, 65535))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // default lifetime: inserts, hit, partial key matches, aging
      issue_request(ACT_LOOKUP, 32'h0000_0000, 10'h000);
      issue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 10'h3FF);
      issue_request(ACT_LOOKUP, 32'h0000_0000, 10'h000);
      issue_request(ACT_LOOKUP, 32'h0000_0000, 10'h3FF);
      issue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 10'h000);
      issue_request(ACT_LOOKUP, 32'hA5A5_5A5A, 10'h155);
      issue_request(ACT_FRAME_END, 32'hFFFF_FFFF, 10'h3FF);

      // zero lifetime survives until the next frame end
      drain_replies();
      write_lifetime(16'd0);
      issue_request(ACT_LOOKUP, 32'h5A5A_A5A5, 10'h2AA);
      issue_request(ACT_LOOKUP, 32'h5A5A_A5A5, 10'h2AA);
      issue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 10'h3FF);
      issue_request(ACT_FRAME_END, 32'h0000_0000, 10'h000);
      issue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 10'h3FF);

      drain_replies();
      write_lifetime(16'd1);
      issue_request(ACT_LOOKUP, 32'h0000_0001, 10'h001);
      issue_request(ACT_FRAME_END, 32'h1234_5678, 10'h0F0);
      issue_request(ACT_LOOKUP, 32'h0000_0000, 10'h000);
      issue_request(ACT_FRAME_END, 32'h8765_4321, 10'h30F);

      drain_replies();
      write_lifetime(16'hFFFF);
      issue_request(ACT_LOOKUP, 32'h8000_0000, 10'h200);
      issue_request(ACT_FRAME_END, 32'h7FFF_FFFF, 10'h1FF);

      for (int p = 0; p < PHASES; p++) random_phase(phase_life[p], PHASE_ITEMS);

      drain_replies();
      if (book.mismatches == 0 && book.waiting() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
src/tkcd_pkg.sv
src/tkcd_req_if.sv
src/tkcd_rsp_if.sv
src/tkcd_ctrl.sv
src/tkcd_dpath.sv
src/ttl_keyed_cache_directory.sv
sim/ttl_keyed_cache_directory_tb.sv
